### rtl/rmms_pkg.sv
// Package with the shared types and codes of the register-mapped multiply/shift unit.
`default_nettype none

package rmms_pkg;

    // Access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register groups.
    localparam logic [1:0] GRP_PARAM  = 2'd0;
    localparam logic [1:0] GRP_RESULT = 2'd1;
    localparam logic [1:0] GRP_SHIFT  = 2'd2;

    // Offsets in the parameter group.
    localparam logic [1:0] OFS_CTRL   = 2'd0;
    localparam logic [1:0] OFS_MCAND  = 2'd1;
    localparam logic [1:0] OFS_MPLIER = 2'd2;
    localparam logic [1:0] OFS_SPARE  = 2'd3;

    // Offset bit 0 in the two-register groups.
    localparam logic RES_LO    = 1'b0;
    localparam logic RES_HI    = 1'b1;
    localparam logic SHF_CTRL  = 1'b0;
    localparam logic SHF_MCAND = 1'b1;

    // Bit positions in the control bytes.
    localparam int CTRL_ACC_BIT    = 7;
    localparam int CTRL_MCAND_BIT  = 1;
    localparam int CTRL_MPLIER_BIT = 0;
    localparam int SHF_SIGN_BIT    = 7;
    localparam int SHF_XOR_BIT     = 6;
    localparam int SHF_HI_BIT      = 3;

    // One bus access as held in the input register.
    typedef struct packed {
        logic       op;
        logic [1:0] group;
        logic [1:0] offset;
        logic [7:0] wdata;
    } t_req;

endpackage

`default_nettype wire

### rtl/rmms_if.sv
// Valid/ready channel interfaces for bus accesses and read data.
`default_nettype none

interface rmms_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [1:0] group;
    logic [1:0] offset;
    logic [7:0] wdata;

    modport source (output valid, output op, output group, output offset, output wdata,
                    input ready);
    modport sink   (input valid, input op, input group, input offset, input wdata,
                    output ready);
endinterface

interface rmms_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;

    modport source (output valid, output rdata, input ready);
    modport sink   (input valid, input rdata, output ready);
endinterface

`default_nettype wire

### rtl/rmms_core.sv
// Register file, multiply-accumulate and shift datapath of the unit.
`default_nettype none

module rmms_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire rmms_pkg::t_req i_req,
    output logic [7:0]         o_rdata
);
    import rmms_pkg::*;

    logic        r_acc_on, n_acc_on;
    logic        r_mcand_sgn, n_mcand_sgn;
    logic        r_mplier_sgn, n_mplier_sgn;
    logic [7:0]  r_mcand, n_mcand;
    logic [7:0]  r_mplier, n_mplier;
    logic [15:0] r_product, n_product;

    logic signed [8:0]  w_mul_a;
    logic signed [8:0]  w_mul_b;
    logic signed [17:0] w_mul_p;
    logic [15:0]        w_mac;
    logic [15:0]        w_shf_ext;
    logic [15:0]        w_shf;
    logic [7:0]         w_lo;
    logic [7:0]         w_hi;

    assign w_lo = r_product[7:0];
    assign w_hi = r_product[15:8];

    // Multiply with the written multiplier; each operand is extended by its sign flag.
    assign w_mul_a = signed'({r_mcand_sgn & r_mcand[7], r_mcand});
    assign w_mul_b = signed'({r_mplier_sgn & i_req.wdata[7], i_req.wdata});
    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_mac   = w_mul_p[15:0] + (r_acc_on ? r_product : 16'd0);

    // Shift multiply: the multiplicand, signed by control bit 7, times a power of two.
    assign w_shf_ext = {{8{i_req.wdata[SHF_SIGN_BIT] & r_mcand[7]}}, r_mcand};
    assign w_shf     = w_shf_ext << i_req.wdata[2:0];

    // Next state for a write access.
    always_comb begin
        n_acc_on     = r_acc_on;
        n_mcand_sgn  = r_mcand_sgn;
        n_mplier_sgn = r_mplier_sgn;
        n_mcand      = r_mcand;
        n_mplier     = r_mplier;
        n_product    = r_product;
        if (i_req.op == OP_WRITE) begin
            case (i_req.group)
                GRP_PARAM: begin
                    case (i_req.offset)
                        OFS_CTRL: begin
                            n_acc_on     = i_req.wdata[CTRL_ACC_BIT];
                            n_mcand_sgn  = i_req.wdata[CTRL_MCAND_BIT];
                            n_mplier_sgn = i_req.wdata[CTRL_MPLIER_BIT];
                        end
                        OFS_MCAND: n_mcand = i_req.wdata;
                        OFS_MPLIER: begin
                            n_mplier  = i_req.wdata;
                            n_product = w_mac;
                        end
                        default: ;
                    endcase
                end
                GRP_RESULT: begin
                    if (i_req.offset[0] == RES_HI) begin
                        n_product = {i_req.wdata, w_lo};
                    end else begin
                        n_product = {w_hi, i_req.wdata};
                    end
                end
                GRP_SHIFT: begin
                    if (i_req.offset[0] == SHF_CTRL) begin
                        n_acc_on     = 1'b0;
                        n_mcand_sgn  = i_req.wdata[SHF_SIGN_BIT];
                        n_mplier_sgn = 1'b0;
                        n_mplier     = i_req.wdata;
                        n_product    = w_shf;
                    end else begin
                        n_mcand = i_req.wdata;
                    end
                end
                default: ;
            endcase
        end
    end

    // Read data; writes return zero.
    always_comb begin
        o_rdata = 8'd0;
        if (i_req.op == OP_READ) begin
            case (i_req.group)
                GRP_PARAM: begin
                    case (i_req.offset)
                        OFS_CTRL: o_rdata = {r_acc_on, 5'd0, r_mcand_sgn, r_mplier_sgn};
                        OFS_MCAND: o_rdata = r_mcand;
                        OFS_MPLIER, OFS_SPARE: o_rdata = r_mplier;
                        default: o_rdata = r_mplier;
                    endcase
                end
                GRP_RESULT: o_rdata = (i_req.offset[0] == RES_HI) ? w_hi : w_lo;
                GRP_SHIFT: begin
                    if (i_req.offset[0] == SHF_CTRL) begin
                        o_rdata = {r_mcand_sgn, r_mplier[6], 3'd0, r_mplier[2:0]};
                    end else if (r_mplier[SHF_XOR_BIT]) begin
                        o_rdata = w_hi ^ w_lo;
                    end else if (r_mplier[SHF_HI_BIT]) begin
                        o_rdata = w_hi;
                    end else begin
                        o_rdata = w_lo;
                    end
                end
                default: o_rdata = 8'd0;
            endcase
        end
    end

    // State registers, updated as the access leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_on     <= 1'b0;
            r_mcand_sgn  <= 1'b0;
            r_mplier_sgn <= 1'b0;
            r_mcand      <= 8'd0;
            r_mplier     <= 8'd0;
            r_product    <= 16'd0;
        end else if (i_fire) begin
            r_acc_on     <= n_acc_on;
            r_mcand_sgn  <= n_mcand_sgn;
            r_mplier_sgn <= n_mplier_sgn;
            r_mcand      <= n_mcand;
            r_mplier     <= n_mplier;
            r_product    <= n_product;
        end
    end

endmodule

`default_nettype wire

### rtl/register_mapped_mac_shift_unit.sv
// Top level of the register-mapped multiply/shift unit: input register, core, output register.
//
//   Channel  Dir  Signals                              Meaning
//   i_req    in   valid ready op group offset wdata    one bus read or write
//   o_rsp    out  valid ready rdata                    read byte, zero for a write
//
// One item is accepted per cycle while the output is not stalled; it passes through the input
// register into the output register, where its result is offered until it is taken.
// The multiply-accumulate runs in the single pass from input register to output register.
// State is updated as an item moves into the output register, so the next item sees it.
// A stalled output holds its item while the input register still accepts one more.
// i_rst_n is synchronous and active low; it zeroes the valid flags and all core state.
`default_nettype none

module register_mapped_mac_shift_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rmms_req_if.sink  i_req,
    rmms_rsp_if.source o_rsp
);
    import rmms_pkg::*;

    logic       r_in_valid;
    t_req       r_in;
    logic       r_out_valid;
    logic [7:0] r_out_rdata;
    logic       w_adv;
    logic       w_take;
    logic [7:0] w_rdata;

    // The input register advances whenever the output register is free or draining.
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_take      = i_req.valid && i_req.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= '{op: i_req.op, group: i_req.group, offset: i_req.offset,
                      wdata: i_req.wdata};
        end
    end

    rmms_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_req   (r_in),
        .o_rdata (w_rdata)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rdata <= w_rdata;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.rdata = r_out_rdata;

    // An item leaving the input register always lands in the output register.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("item left input register but output register is empty");

    // A write access delivers zero read data.
    a_write_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.op == OP_WRITE) |=> (o_rsp.rdata == 8'd0))
        else $error("write access returned nonzero read data");

    // A held input register never takes a new item.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> !i_req.ready)
        else $error("input accepted while input register is held");

endmodule

`default_nettype wire

### tb/register_mapped_mac_shift_unit_test.sv
// Self-checking testbench of the register-mapped multiply/shift unit, with its own bus-level predictor.
`default_nettype none

module register_mapped_mac_shift_unit_test;
    import rmms_pkg::*;

    // Group code that no register decodes, and the bits echoed by a shift control read.
    localparam logic [1:0] GRP_UNUSED    = 2'd3;
    localparam logic [7:0] SHF_ECHO_MASK = 8'h47;

    // Marks a table row whose read byte is typed in rather than predicted.
    localparam logic FIXED = 1'b1;
    localparam logic PRED  = 1'b0;

    localparam int N_DIRECTED   = 26;
    localparam int N_RANDOM     = 525;
    localparam int N_QUIET_TAIL = 100;

    typedef struct packed {
        t_req       acc;
        logic       fixed;
        logic [7:0] fixed_rdata;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rmms_req_if req_ch ();
    rmms_rsp_if rsp_ch ();

    register_mapped_mac_shift_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predicted unit state.
    logic [7:0]  pm_mplier;
    logic [7:0]  pm_mcand;
    logic        pm_acc_on;
    logic        pm_mcand_signed;
    logic        pm_mplier_signed;
    logic [15:0] pm_product;

    logic [7:0] rdata_expected_q [$];
    int         mismatch_count = 0;
    int         rdata_seen = 0;
    bit         idle_on = 1'b1;
    int         stall_left = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR: %s", msg);
    endtask

    // One multiply of the multiplicand by mul_in, wrapped to 16 bits, optionally accumulated.
    function automatic void mac_update(input logic [7:0] mul_in);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] p;
        a = pm_mcand_signed ? {{8{pm_mcand[7]}}, pm_mcand} : {8'h00, pm_mcand};
        b = pm_mplier_signed ? {{8{mul_in[7]}}, mul_in} : {8'h00, mul_in};
        p = a * b;
        if (pm_acc_on) begin
            p = p + pm_product;
        end
        pm_product = p;
    endfunction

    // Applies one bus access to the predicted state and returns the byte the bus sees.
    function automatic logic [7:0] predict_bus_access(input t_req acc);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] rd;
        lo = pm_product[7:0];
        hi = pm_product[15:8];
        rd = 8'h00;
        if (acc.op == OP_WRITE) begin
            case (acc.group)
                GRP_PARAM: begin
                    case (acc.offset)
                        OFS_CTRL: begin
                            pm_acc_on        = acc.wdata[CTRL_ACC_BIT];
                            pm_mcand_signed  = acc.wdata[CTRL_MCAND_BIT];
                            pm_mplier_signed = acc.wdata[CTRL_MPLIER_BIT];
                        end
                        OFS_MCAND: pm_mcand = acc.wdata;
                        OFS_MPLIER: begin
                            pm_mplier = acc.wdata;
                            mac_update(pm_mplier);
                        end
                        default: ;
                    endcase
                end
                GRP_RESULT: begin
                    if (acc.offset[0] == RES_HI) begin
                        pm_product = {acc.wdata, lo};
                    end else begin
                        pm_product = {hi, acc.wdata};
                    end
                end
                GRP_SHIFT: begin
                    if (acc.offset[0] == SHF_CTRL) begin
                        pm_acc_on        = 1'b0;
                        pm_mcand_signed  = acc.wdata[SHF_SIGN_BIT];
                        pm_mplier_signed = 1'b0;
                        pm_mplier        = acc.wdata;
                        mac_update(8'd1 << acc.wdata[2:0]);
                    end else begin
                        pm_mcand = acc.wdata;
                    end
                end
                default: ;
            endcase
        end else begin
            case (acc.group)
                GRP_PARAM: begin
                    case (acc.offset)
                        OFS_CTRL: begin
                            rd[CTRL_ACC_BIT]    = pm_acc_on;
                            rd[CTRL_MCAND_BIT]  = pm_mcand_signed;
                            rd[CTRL_MPLIER_BIT] = pm_mplier_signed;
                        end
                        OFS_MCAND: rd = pm_mcand;
                        default: rd = pm_mplier;
                    endcase
                end
                GRP_RESULT: rd = (acc.offset[0] == RES_HI) ? hi : lo;
                GRP_SHIFT: begin
                    if (acc.offset[0] == SHF_CTRL) begin
                        rd = pm_mplier & SHF_ECHO_MASK;
                        rd[SHF_SIGN_BIT] = pm_mcand_signed;
                    end else if (pm_mplier[SHF_XOR_BIT]) begin
                        rd = hi ^ lo;
                    end else if (pm_mplier[SHF_HI_BIT]) begin
                        rd = hi;
                    end else begin
                        rd = lo;
                    end
                end
                default: ;
            endcase
        end
        return rd;
    endfunction

    function automatic t_req make_access(input logic op, input logic [1:0] grp,
                                         input logic [1:0] ofs, input logic [7:0] wd);
        t_req r;
        r.op     = op;
        r.group  = grp;
        r.offset = ofs;
        r.wdata  = wd;
        return r;
    endfunction

    // Random byte that lands on the sign and range extremes fairly often.
    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        v = 8'($urandom);
        case ($urandom_range(0, 7))
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = 8'h80;
            3: v = 8'h7F;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_req rand_access();
        logic       op;
        logic [1:0] grp;
        int         pick;
        pick = $urandom_range(0, 99);
        op   = ($urandom_range(0, 9) < 4) ? OP_READ : OP_WRITE;
        if (pick < 40) begin
            grp = GRP_PARAM;
        end else if (pick < 60) begin
            grp = GRP_RESULT;
        end else if (pick < 94) begin
            grp = GRP_SHIFT;
        end else begin
            grp = GRP_UNUSED;
        end
        return make_access(op, grp, 2'($urandom_range(0, 3)), rand_byte());
    endfunction

    // Presents one item, waits for its acceptance, then records the byte it should return.
    task automatic send_access(input t_req acc, input logic fixed, input logic [7:0] fixed_rdata);
        logic [7:0] predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= acc.op;
        req_ch.group  <= acc.group;
        req_ch.offset <= acc.offset;
        req_ch.wdata  <= acc.wdata;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predicted = predict_bus_access(acc);
        rdata_expected_q.push_back(fixed ? fixed_rdata : predicted);
    endtask

    // Result side back-pressure: ready is dropped in random bursts; new bursts start only while idle_on is set.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Each accepted read byte is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rdata_expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d: rdata %02h arrived with no item pending",
                                          rdata_seen, rsp_ch.rdata));
            end else if (rsp_ch.rdata !== rdata_expected_q[0]) begin
                report_mismatch($sformatf("result %0d: rdata %02h, expected %02h",
                                          rdata_seen, rsp_ch.rdata, rdata_expected_q[0]));
                void'(rdata_expected_q.pop_front());
            end else begin
                void'(rdata_expected_q.pop_front());
            end
            rdata_seen++;
        end
    end

    initial begin
        t_dir_row dir_rows [N_DIRECTED];
        t_req     batch [$];
        int       sent;
        int       kind;
        int       wait_cycles;

        req_ch.valid  = 1'b0;
        req_ch.op     = OP_READ;
        req_ch.group  = GRP_PARAM;
        req_ch.offset = OFS_CTRL;
        req_ch.wdata  = 8'h00;
        rsp_ch.ready  = 1'b1;

        pm_mplier        = 8'h00;
        pm_mcand         = 8'h00;
        pm_acc_on        = 1'b0;
        pm_mcand_signed  = 1'b0;
        pm_mplier_signed = 1'b0;
        pm_product       = 16'h0000;

        // Directed items: op, group, offset, wdata, fixed or predicted, fixed byte.
        dir_rows = '{
            // Reset state, then control byte with every bit set.
            {OP_READ,  GRP_PARAM,  OFS_CTRL,          8'h00, FIXED, 8'h00},
            {OP_READ,  GRP_RESULT, {1'b1, RES_HI},    8'hFF, FIXED, 8'h00},
            {OP_WRITE, GRP_PARAM,  OFS_CTRL,          8'hFF, FIXED, 8'h00},
            {OP_READ,  GRP_PARAM,  OFS_CTRL,          8'h00, FIXED, 8'h83},
            // Signed extremes with accumulation.
            {OP_WRITE, GRP_PARAM,  OFS_MCAND,         8'hFF, FIXED, 8'h00},
            {OP_WRITE, GRP_PARAM,  OFS_MPLIER,        8'hFF, FIXED, 8'h00},
            {OP_READ,  GRP_RESULT, {1'b0, RES_LO},    8'h00, PRED,  8'h00},
            {OP_WRITE, GRP_PARAM,  OFS_MPLIER,        8'h80, FIXED, 8'h00},
            {OP_READ,  GRP_RESULT, {1'b0, RES_LO},    8'h00, PRED,  8'h00},
            // Unused control bits are dropped; unsigned full-scale multiply.
            {OP_WRITE, GRP_PARAM,  OFS_CTRL,          8'h7C, FIXED, 8'h00},
            {OP_READ,  GRP_PARAM,  OFS_CTRL,          8'h00, FIXED, 8'h00},
            {OP_WRITE, GRP_PARAM,  OFS_MPLIER,        8'hFF, PRED,  8'h00},
            {OP_READ,  GRP_RESULT, {1'b0, RES_HI},    8'h00, PRED,  8'h00},
            // Spare parameter offset and the unused group.
            {OP_WRITE, GRP_PARAM,  OFS_SPARE,         8'h55, FIXED, 8'h00},
            {OP_READ,  GRP_PARAM,  OFS_SPARE,         8'h00, FIXED, 8'hFF},
            {OP_WRITE, GRP_UNUSED, 2'd0,              8'hAA, FIXED, 8'h00},
            {OP_READ,  GRP_UNUSED, 2'd1,              8'h00, FIXED, 8'h00},
            // Result preset, then the XOR read path.
            {OP_WRITE, GRP_RESULT, {1'b1, RES_LO},    8'h34, FIXED, 8'h00},
            {OP_WRITE, GRP_RESULT, {1'b0, RES_HI},    8'h12, FIXED, 8'h00},
            {OP_READ,  GRP_SHIFT,  {1'b0, SHF_MCAND}, 8'h00, PRED,  8'h00},
            // Shift by seven: 0x80 is taken signed, as control bit 7 is set.
            {OP_WRITE, GRP_SHIFT,  {1'b1, SHF_MCAND}, 8'h80, FIXED, 8'h00},
            {OP_WRITE, GRP_SHIFT,  {1'b0, SHF_CTRL},  8'h87, FIXED, 8'h00},
            {OP_READ,  GRP_SHIFT,  {1'b1, SHF_CTRL},  8'h00, PRED,  8'h00},
            {OP_READ,  GRP_SHIFT,  {1'b0, SHF_MCAND}, 8'h00, PRED,  8'h00},
            // High byte selection.
            {OP_WRITE, GRP_SHIFT,  {1'b0, SHF_CTRL},  8'h08, FIXED, 8'h00},
            {OP_READ,  GRP_SHIFT,  {1'b1, SHF_MCAND}, 8'h00, PRED,  8'h00}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_access(dir_rows[i].acc, dir_rows[i].fixed, dir_rows[i].fixed_rdata);
        end

        // Random part: mostly complete multiply or shift sequences, the rest loose accesses.
        sent = 0;
        while (sent < N_RANDOM) begin
            batch.delete();
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                batch.push_back(make_access(OP_WRITE, GRP_PARAM, OFS_CTRL, rand_byte()));
                batch.push_back(make_access(OP_WRITE, GRP_PARAM, OFS_MCAND, rand_byte()));
                repeat ($urandom_range(1, 3)) begin
                    batch.push_back(make_access(OP_WRITE, GRP_PARAM, OFS_MPLIER, rand_byte()));
                end
                batch.push_back(make_access(OP_READ, GRP_RESULT,
                                            {1'($urandom_range(0, 1)), RES_LO}, rand_byte()));
                batch.push_back(make_access(OP_READ, GRP_RESULT,
                                            {1'($urandom_range(0, 1)), RES_HI}, rand_byte()));
            end else if (kind < 6) begin
                batch.push_back(make_access(OP_WRITE, GRP_SHIFT, {1'b0, SHF_MCAND}, rand_byte()));
                batch.push_back(make_access(OP_WRITE, GRP_SHIFT, {1'b0, SHF_CTRL}, rand_byte()));
                batch.push_back(make_access(OP_READ, GRP_SHIFT,
                                            {1'($urandom_range(0, 1)), SHF_MCAND}, rand_byte()));
                batch.push_back(make_access(OP_READ, GRP_SHIFT, {1'b0, SHF_CTRL}, rand_byte()));
            end else begin
                batch.push_back(rand_access());
            end
            foreach (batch[j]) begin
                send_access(batch[j], PRED, 8'h00);
                sent++;
                if (sent >= N_RANDOM - N_QUIET_TAIL) begin
                    idle_on = 1'b0;
                end
            end
        end
        req_ch.valid <= 1'b0;

        // Drain the outstanding read bytes.
        wait_cycles = 0;
        while (rdata_expected_q.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (rdata_expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      rdata_expected_q.size()));
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/rmms_pkg.sv
rtl/rmms_if.sv
rtl/rmms_core.sv
rtl/register_mapped_mac_shift_unit.sv
tb/register_mapped_mac_shift_unit_test.sv
